/* rtl/core/asms_pkg.sv */
`default_nettype none
package asms_pkg;

    localparam int FRAC = 16;
    localparam int MW = 34;
    localparam int PW = 2 * MW;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W = 31;
    localparam int TS_W = 17;

    localparam longint PI_Q32 = 64'sd13493037705;
    localparam longint PI_Q = (PI_Q32 + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
    localparam logic signed [33:0] PI_V = 34'(PI_Q);
    localparam logic signed [33:0] TWO_PI_V = 34'(2 * PI_Q);

    localparam int SQ_XW = 32 + FRAC;
    localparam int SQ_RW = (SQ_XW + 1) / 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KA   = 3'd0,
        CFG_K2   = 3'd1,
        CFG_KAL  = 3'd2,
        CFG_KMIN = 3'd3,
        CFG_MIU  = 3'd4,
        CFG_TS   = 3'd5,
        CFG_FS   = 3'd6,
        CFG_ANG  = 3'd7
    } t_cfg_idx;

    function automatic logic signed [PW-1:0] ext_w(input logic signed [31:0] v);
        return {{(PW-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        if (v > $signed(PW'(64'sd2147483647))) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -$signed(PW'(64'sd2147483648))) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/asms_in_if.sv */
`default_nettype none
interface asms_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] measured;
    logic signed [31:0] target;

    modport source (output valid, output cmd, output measured, output target, input ready);
    modport sink (input valid, input cmd, input measured, input target, output ready);
endinterface
`default_nettype wire

/* rtl/core/asms_out_if.sv */
`default_nettype none
interface asms_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic signed [31:0] surface;
    logic signed [31:0] adaptive_gain;
    logic signed [31:0] error_rate;

    modport source (output valid, output drive, output surface, output adaptive_gain,
                    output error_rate, input ready);
    modport sink (input valid, input drive, input surface, input adaptive_gain,
                  input error_rate, output ready);
endinterface
`default_nettype wire

/* rtl/core/asms_div.sv */
`default_nettype none
module asms_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_busy,
    output logic signed [31:0] o_ratio
);
    import asms_pkg::*;

    localparam int DW = 33 + FRAC;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [33:0]   r_rem;
    logic [32:0]   r_den;
    logic          r_neg;
    logic signed [31:0] r_ratio;

    logic [33:0]   rem_sh;
    logic          ge;
    logic [33:0]   rem_nx;
    logic [DW-1:0] q_nx;
    logic [32:0]   num_mag;
    logic [32:0]   den_mag;
    logic signed [PW-1:0] q_ext;

    always_comb begin
        rem_sh  = {r_rem[32:0], r_q[DW-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_nx  = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
        q_nx    = {r_q[DW-2:0], ge};
        num_mag = i_num[32] ? 33'(-i_num) : 33'(i_num);
        den_mag = i_den[32] ? 33'(-i_den) : 33'(i_den);
        q_ext   = $signed(PW'(q_nx));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            if (i_den == '0) begin
                r_ratio <= '0;
            end else begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end
            r_q   <= {num_mag, {FRAC{1'b0}}};
            r_rem <= '0;
            r_den <= den_mag;
            r_neg <= i_num[32] ^ i_den[32];
        end else if (r_busy) begin
            r_q   <= q_nx;
            r_rem <= rem_nx;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy  <= 1'b0;
                r_ratio <= sat32(r_neg ? -q_ext : q_ext);
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_ratio = r_ratio;
endmodule
`default_nettype wire

/* rtl/core/asms_sqrt.sv */
`default_nettype none
module asms_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [31:0]                 i_mag,
    output logic                        o_busy,
    output logic [asms_pkg::SQ_RW-1:0]  o_root
);
    import asms_pkg::*;

    localparam logic [SQ_XW-1:0] BIT0 = SQ_XW'(1) << (2 * ((SQ_XW - 1) / 2));

    logic [SQ_XW-1:0] r_x;
    logic [SQ_XW-1:0] r_res;
    logic [SQ_XW-1:0] r_bit;
    logic [SQ_XW-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_x   <= {i_mag, {FRAC{1'b0}}};
            r_res <= '0;
            r_bit <= BIT0;
        end else if (r_bit != '0) begin
            if (r_x >= trial) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_bit != '0;
    assign o_root = r_res[SQ_RW-1:0];
endmodule
`default_nettype wire

/* rtl/core/adaptive_sliding_mode_step.sv */
`default_nettype none
// Adaptive super-twisting sliding mode controller, one control step per item.
// Input channel i_in carries cmd, measured and target; output channel o_out
// returns drive, surface, adaptive_gain and error_rate, one result per item.
// Gains and timing are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write them only while the block is idle, as the block
// itself does not enforce this. A write takes effect at the next clock edge.
// A step item runs through a sequencer around one registered 34x34
// multiplier (seven products), a radix-2 divider for the adaptation ratio
// and a digit-recurrence square root that runs alongside the divider.
// When the ratio denominator is zero only the root runs.
// A history-reset item (cmd = 1) yields its result in the cycle after it
// is accepted. i_in.ready is high only while no item is in work and no
// result waits, so a new item is taken only after the last result has
// been taken.
// When the receiver stalls, the result holds on o_out until taken.
// Reset clears the history, the adaptive gain and the configuration to
// its defaults; no clearing pass is needed.
module adaptive_sliding_mode_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    asms_in_if.sink                             i_in,
    asms_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [asms_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [asms_pkg::CFG_W-1:0]          i_cfg_data
);
    import asms_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_MRATE = 17'h00002,
        S_URATE = 17'h00004,
        S_MINT  = 17'h00008,
        S_UINT  = 17'h00010,
        S_MSIG  = 17'h00020,
        S_USIG  = 17'h00040,
        S_START = 17'h00080,
        S_WAIT  = 17'h00100,
        S_MDG   = 17'h00200,
        S_UDG   = 17'h00400,
        S_MK1   = 17'h00800,
        S_UK1   = 17'h01000,
        S_MTERM = 17'h02000,
        S_UTERM = 17'h04000,
        S_MLIN  = 17'h08000,
        S_OUT   = 17'h10000
    } t_state;

    t_state r_state;

    // configuration
    logic [CFG_W-1:0] r_ka, r_k2, r_kal, r_kmin, r_miu, r_fs;
    logic [TS_W-1:0]  r_ts;
    logic             r_ang;

    // history
    logic signed [31:0] r_last_e, r_integ, r_gain, r_last_dg;

    // step working values
    logic signed [31:0] r_e, r_rate, r_sigma, r_dgain, r_k1;
    logic signed [PW-1:0] r_term;
    logic               r_gt;
    logic signed [PW-1:0] r_prod;

    // result registers
    logic signed [31:0] r_o_drive, r_o_sigma, r_o_gain, r_o_rate;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [33:0]   e34, le34, w_e, w_rate;
    logic signed [PW-1:0] sh_f, sh_f1, lin, drv;
    logic [31:0]          mag;
    logic signed [32:0]   div_num, div_den;
    logic                 unit_start, div_busy, sq_busy;
    logic signed [31:0]   ratio;
    logic [SQ_RW-1:0]     root;

    assign e34  = {{2{r_e[31]}}, r_e};
    assign le34 = {{2{r_last_e[31]}}, r_last_e};
    assign sh_f  = r_prod >>> FRAC;
    assign sh_f1 = r_prod >>> (FRAC + 1);
    assign lin   = sh_f;
    assign mag   = r_sigma[31] ? (~r_sigma + 32'sd1) : r_sigma;
    assign div_num = {r_sigma[31], r_sigma} - $signed({2'b00, r_miu});
    assign div_den = $signed({1'b0, mag}) - $signed({2'b00, r_miu});
    assign unit_start = r_state == S_START;

    // wrap by two pi outside [-pi, pi]
    always_comb begin
        w_e = e34;
        if (e34 > PI_V) begin
            w_e = e34 - TWO_PI_V;
        end else if (e34 < -PI_V) begin
            w_e = e34 + TWO_PI_V;
        end
        w_rate = {{2{r_rate[31]}}, r_rate};
        if (w_rate > PI_V) begin
            w_rate = w_rate - TWO_PI_V;
        end else if (w_rate < -PI_V) begin
            w_rate = w_rate + TWO_PI_V;
        end
    end

    always_comb begin
        if (r_sigma > 32'sd0) begin
            drv = -r_term - lin;
        end else if (r_sigma < 32'sd0) begin
            drv = r_term - lin;
        end else begin
            drv = -lin;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MRATE: begin
                mul_a = e34 - le34;
                mul_b = $signed({3'b000, r_fs});
            end
            S_MINT: begin
                mul_a = e34 + le34;
                mul_b = $signed({{(MW-TS_W){1'b0}}, r_ts});
            end
            S_MSIG: begin
                mul_a = $signed({3'b000, r_ka});
                mul_b = {{2{r_integ[31]}}, r_integ};
            end
            S_MDG: begin
                mul_a = $signed({3'b000, r_kal});
                mul_b = {{2{ratio[31]}}, ratio};
            end
            S_MK1: begin
                mul_a = {{2{r_dgain[31]}}, r_dgain} + {{2{r_last_dg[31]}}, r_last_dg};
                mul_b = $signed({{(MW-TS_W){1'b0}}, r_ts});
            end
            S_MTERM: begin
                mul_a = {{2{r_k1[31]}}, r_k1};
                mul_b = $signed({{(MW-SQ_RW){1'b0}}, root});
            end
            S_MLIN: begin
                mul_a = $signed({3'b000, r_k2});
                mul_b = {{2{r_sigma[31]}}, r_sigma};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ka   <= '0;
            r_k2   <= '0;
            r_kal  <= '0;
            r_kmin <= '0;
            r_miu  <= '0;
            r_ts   <= TS_W'(655);
            r_fs   <= CFG_W'(6553600);
            r_ang  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KA:   r_ka   <= i_cfg_data;
                CFG_K2:   r_k2   <= i_cfg_data;
                CFG_KAL:  r_kal  <= i_cfg_data;
                CFG_KMIN: r_kmin <= i_cfg_data;
                CFG_MIU:  r_miu  <= i_cfg_data;
                CFG_TS:   r_ts   <= i_cfg_data[TS_W-1:0];
                CFG_FS:   r_fs   <= i_cfg_data;
                CFG_ANG:  r_ang  <= i_cfg_data[0];
                default:  r_ang  <= r_ang;
            endcase
        end
    end

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last_e  <= '0;
            r_integ   <= '0;
            r_gain    <= '0;
            r_last_dg <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.cmd) begin
                            // clear last error and integral, keep gain
                            r_last_e  <= '0;
                            r_integ   <= '0;
                            r_o_sigma <= '0;
                            r_o_gain  <= r_gain;
                            r_o_rate  <= '0;
                            r_state   <= S_OUT;
                        end else begin
                            r_e     <= sat32(ext_w(i_in.target) - ext_w(i_in.measured));
                            r_state <= S_MRATE;
                        end
                    end
                end
                S_MRATE: r_state <= S_URATE;
                S_URATE: begin
                    r_rate  <= sat32(sh_f);
                    r_state <= S_MINT;
                end
                S_MINT: r_state <= S_UINT;
                S_UINT: begin
                    r_integ <= sat32(ext_w(r_integ) + sh_f1);
                    if (r_ang) begin
                        r_e      <= w_e[31:0];
                        r_last_e <= w_e[31:0];
                        r_rate   <= w_rate[31:0];
                    end else begin
                        r_last_e <= r_e;
                    end
                    r_state <= S_MSIG;
                end
                S_MSIG: r_state <= S_USIG;
                S_USIG: begin
                    r_sigma <= sat32(ext_w(r_e) + sh_f);
                    r_gt    <= r_gain > $signed({1'b0, r_kmin});
                    r_state <= S_START;
                end
                S_START: r_state <= S_WAIT;
                S_WAIT: begin
                    if (!div_busy && !sq_busy) begin
                        r_state <= S_MDG;
                    end
                end
                S_MDG: r_state <= S_UDG;
                S_UDG: begin
                    r_dgain <= r_gt ? sat32(sh_f) : $signed({1'b0, r_kmin});
                    r_state <= S_MK1;
                end
                S_MK1: r_state <= S_UK1;
                S_UK1: begin
                    r_k1      <= sat32(ext_w(r_gain) + sh_f1);
                    r_gain    <= sat32(ext_w(r_gain) + sh_f1);
                    r_last_dg <= r_dgain;
                    r_state   <= S_MTERM;
                end
                S_MTERM: r_state <= S_UTERM;
                S_UTERM: begin
                    r_term  <= sh_f;
                    r_state <= S_MLIN;
                end
                S_MLIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready && !r_drv_pend) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // result capture in S_MLIN, as the linear product is registered
            if (r_state == S_MLIN) begin
                r_o_sigma <= r_sigma;
                r_o_gain  <= r_k1;
                r_o_rate  <= r_rate;
            end
        end
    end

    // drive is formed from the linear product as it leaves the multiplier
    logic r_drv_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drv_pend <= 1'b0;
        end else begin
            r_drv_pend <= r_state == S_MLIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_drv_pend) begin
            r_o_drive <= sat32(drv);
        end else if (r_state == S_IDLE && i_in.valid && i_in.cmd) begin
            r_o_drive <= '0;
        end
    end

    asms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (unit_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_ratio (ratio)
    );

    asms_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (unit_start),
        .i_mag   (mag),
        .o_busy  (sq_busy),
        .o_root  (root)
    );

    assign i_in.ready          = r_state == S_IDLE;
    assign o_out.valid         = (r_state == S_OUT) && !r_drv_pend;
    assign o_out.drive         = r_o_drive;
    assign o_out.surface       = r_o_sigma;
    assign o_out.adaptive_gain = r_o_gain;
    assign o_out.error_rate    = r_o_rate;
endmodule
`default_nettype wire

/* rtl/core/asms_check.sv */
`default_nettype none
module asms_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_cmd,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_drive
);
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready while an item is in work");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while a result waits");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_cmd |=> i_out_valid && i_out_drive == 32'd0)
        else $error("history reset item gave a wrong result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_drive))
        else $error("stalled result changed");
endmodule

bind adaptive_sliding_mode_step asms_check u_asms_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_drive (o_out.drive)
);
`default_nettype wire
